@@ rtl/brr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the block prefetch ring receiver.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package brr_pkg;

    // Action codes carried on the input channel.
    localparam logic [2:0] ACT_NEW_FILE  = 3'd0;
    localparam logic [2:0] ACT_BLOCK_BYTE = 3'd1;
    localparam logic [2:0] ACT_READ_BYTE = 3'd2;
    localparam logic [2:0] ACT_TICK      = 3'd3;
    localparam logic [2:0] ACT_RETRY     = 3'd4;

    // Request index that marks the end of a transfer.
    localparam logic [31:0] END_INDEX = 32'hFFFF_FFFF;

    // Timeout register value after reset.
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;

    // Depth of the command queue between the front and back ends.
    localparam int CMD_DEPTH = 2;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] file_size_in;
        logic [7:0]  block_byte;
        logic        block_last;
        logic        link_accept;
    } t_in_item;

    typedef struct packed {
        logic        req_sent;
        logic [31:0] req_index;
        logic        byte_valid;
        logic [7:0]  byte_value;
        logic [31:0] position;
        logic        opened;
        logic        busy_res;
        logic        cached;
    } t_out_item;

    // Decoded operation handed from the front end to the back end.
    typedef enum logic [2:0] {
        OP_NEW,
        OP_BYTE,
        OP_READ,
        OP_TICK,
        OP_RETRY,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] size;
        logic [7:0]  data;
        logic        last;
        logic        accept;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_beat;

    typedef struct packed {
        logic opened;
        logic closing;
        logic cached;
        logic busy;
    } t_flags;

    // Outcome of a send attempt: updated flags and what went out on the link.
    typedef struct packed {
        t_flags flags;
        logic   sent;
        logic   is_end;
        logic   arm;
    } t_send;

    typedef enum logic {
        BK_EXEC,
        BK_READ
    } t_bk_state;

endpackage

@@ rtl/brr_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input events and the result beats.
// Depends on brr_pkg for the payload types.
interface brr_in_if;
    logic               valid;
    logic               ready;
    brr_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface brr_out_if;
    logic               valid;
    logic               ready;
    brr_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/brr_front.sv @@
`timescale 1ns / 1ps
// Front end: takes input beats and decodes the action into a queue command.
// Depends on brr_pkg and brr_if.
module brr_front (
    brr_in_if.sink              i_in,
    input  logic                i_q_ready,
    output brr_pkg::t_cmd_beat  o_push
);

    always_comb begin
        o_push.valid      = i_in.valid;
        o_push.cmd.size   = i_in.data.file_size_in;
        o_push.cmd.data   = i_in.data.block_byte;
        o_push.cmd.last   = i_in.data.block_last;
        o_push.cmd.accept = i_in.data.link_accept;
        unique case (i_in.data.action)
            brr_pkg::ACT_NEW_FILE:   o_push.cmd.op = brr_pkg::OP_NEW;
            brr_pkg::ACT_BLOCK_BYTE: o_push.cmd.op = brr_pkg::OP_BYTE;
            brr_pkg::ACT_READ_BYTE:  o_push.cmd.op = brr_pkg::OP_READ;
            brr_pkg::ACT_TICK:       o_push.cmd.op = brr_pkg::OP_TICK;
            brr_pkg::ACT_RETRY:      o_push.cmd.op = brr_pkg::OP_RETRY;
            default:                 o_push.cmd.op = brr_pkg::OP_NOP;
        endcase
    end

    assign i_in.ready = i_q_ready;

endmodule

@@ rtl/brr_cmd_queue.sv @@
`timescale 1ns / 1ps
// Short command FIFO that decouples the front end from the back end.
// Depends on brr_pkg.
module brr_cmd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  brr_pkg::t_cmd_beat  i_push,
    output logic                o_ready,
    output brr_pkg::t_cmd_beat  o_head,
    input  logic                i_pop
);

    localparam int PW = (brr_pkg::CMD_DEPTH > 1) ? $clog2(brr_pkg::CMD_DEPTH) : 1;
    localparam int CW = $clog2(brr_pkg::CMD_DEPTH + 1);

    brr_pkg::t_cmd r_buf [brr_pkg::CMD_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          push;

    assign o_ready     = (r_count != CW'(brr_pkg::CMD_DEPTH));
    assign push        = i_push.valid && o_ready;
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd  = r_buf[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(brr_pkg::CMD_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(brr_pkg::CMD_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= i_push.cmd;
        end
    end

endmodule

@@ rtl/brr_back.sv @@
`timescale 1ns / 1ps
// Back end: executes queued commands against the ring state and slot memory,
// and holds the result register. Depends on brr_pkg and brr_if.
module brr_back #(
    parameter int BLOCK_BYTES = 64,
    parameter int BLOCK_SLOTS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  brr_pkg::t_cmd_beat  i_head,
    output logic                o_pop,
    input  logic                i_cfg_wr_en,
    input  logic [15:0]         i_cfg_wr_data,
    brr_out_if.source           o_out
);

    localparam int RING_BYTES = BLOCK_BYTES * BLOCK_SLOTS;
    localparam int AW = $clog2(RING_BYTES);
    localparam int OW = $clog2(BLOCK_BYTES);
    localparam int FW = $clog2(BLOCK_BYTES + 1);
    localparam int SW = $clog2(BLOCK_SLOTS);
    localparam logic [32:0] WB_STEP = 33'(BLOCK_BYTES);
    localparam logic [BLOCK_SLOTS-1:0] SLOT_ONE = {{(BLOCK_SLOTS-1){1'b0}}, 1'b1};

    // A stop goes out at once unless a request is still outstanding or the link refuses it.
    function automatic brr_pkg::t_send send_stop(brr_pkg::t_flags f, logic acc);
        brr_pkg::t_send r;
        r.flags  = f;
        r.sent   = 1'b0;
        r.is_end = 1'b0;
        r.arm    = 1'b0;
        if (f.busy) begin
            r.flags.closing = 1'b1;
        end else if (acc) begin
            r.sent          = 1'b1;
            r.is_end        = 1'b1;
            r.flags.cached  = 1'b0;
            r.flags.closing = 1'b0;
            r.flags.opened  = 1'b0;
        end else begin
            r.flags.cached  = 1'b1;
            r.flags.closing = 1'b1;
        end
        return r;
    endfunction

    function automatic brr_pkg::t_send send_request(brr_pkg::t_flags f, logic done,
                                                    logic acc);
        brr_pkg::t_send r;
        r.flags  = f;
        r.sent   = 1'b0;
        r.is_end = 1'b0;
        r.arm    = 1'b0;
        if (!f.busy) begin
            if (done) begin
                if (f.opened) begin
                    r = send_stop(f, acc);
                end
            end else if (acc) begin
                r.sent         = 1'b1;
                r.arm          = 1'b1;
                r.flags.busy   = 1'b1;
                r.flags.cached = 1'b0;
            end else begin
                r.flags.cached = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic brr_pkg::t_send follow_up(brr_pkg::t_flags f, logic full,
                                                 logic done, logic acc);
        brr_pkg::t_send r;
        r.flags  = f;
        r.sent   = 1'b0;
        r.is_end = 1'b0;
        r.arm    = 1'b0;
        if (f.closing) begin
            r = send_stop(f, acc);
        end else if (!full) begin
            r = send_request(f, done, acc);
        end
        return r;
    endfunction

    brr_pkg::t_bk_state     r_state, n_state;
    logic [15:0]            r_ticks, n_ticks;
    logic [31:0]            r_size, n_size;
    logic [31:0]            r_wblocks, n_wblocks;
    logic [32:0]            r_wbytes, n_wbytes;
    logic [SW-1:0]          r_wslot, n_wslot;
    logic [FW-1:0]          r_fill, n_fill;
    logic [SW-1:0]          r_rslot, n_rslot;
    logic [OW-1:0]          r_roff, n_roff;
    logic [31:0]            r_pos, n_pos;
    logic [BLOCK_SLOTS-1:0] r_vm, n_vm;
    brr_pkg::t_flags        r_flags, n_flags;
    logic [15:0]            r_tleft, n_tleft;
    brr_pkg::t_out_item     r_res, n_res;
    logic                   r_out_valid, n_out_valid;

    logic [7:0]             r_mem [RING_BYTES];
    logic [7:0]             r_rd_data;
    logic                   mem_we, mem_re;
    logic [AW-1:0]          wr_addr, rd_addr;

    // One mark per ring byte: set when the byte is written in the current file.
    logic [RING_BYTES-1:0]  r_mark;
    logic                   r_rd_mark;
    logic                   mark_clr;

    brr_pkg::t_flags        fl;
    brr_pkg::t_send         fu;
    logic                   called;
    logic                   got;
    logic                   done_now;
    logic [15:0]            tick_left;

    assign wr_addr  = AW'(r_wslot) * AW'(BLOCK_BYTES) + AW'(r_fill);
    assign rd_addr  = AW'(r_rslot) * AW'(BLOCK_BYTES) + AW'(r_roff);
    assign done_now = (r_wbytes >= {1'b0, r_size});

    always_comb begin
        n_state     = r_state;
        n_ticks     = r_ticks;
        n_size      = r_size;
        n_wblocks   = r_wblocks;
        n_wbytes    = r_wbytes;
        n_wslot     = r_wslot;
        n_fill      = r_fill;
        n_rslot     = r_rslot;
        n_roff      = r_roff;
        n_pos       = r_pos;
        n_vm        = r_vm;
        n_flags     = r_flags;
        n_tleft     = r_tleft;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mark_clr    = 1'b0;
        fl          = r_flags;
        fu.flags    = r_flags;
        fu.sent     = 1'b0;
        fu.is_end   = 1'b0;
        fu.arm      = 1'b0;
        called      = 1'b0;
        got         = 1'b0;
        tick_left   = (r_tleft != '0) ? r_tleft - 16'd1 : '0;

        if (i_cfg_wr_en) begin
            n_ticks = i_cfg_wr_data;
        end

        unique case (r_state)
            brr_pkg::BK_EXEC: begin
                if (r_out_valid && o_out.ready) begin
                    n_out_valid = 1'b0;
                end
                if (i_head.valid && (!r_out_valid || o_out.ready)) begin
                    o_pop = 1'b1;
                    unique case (i_head.cmd.op)
                        brr_pkg::OP_NEW: begin
                            n_size    = '0;
                            n_wblocks = '0;
                            n_wbytes  = '0;
                            n_wslot   = '0;
                            n_fill    = '0;
                            n_rslot   = '0;
                            n_roff    = '0;
                            n_pos     = '0;
                            n_vm      = '0;
                            n_tleft   = '0;
                            mark_clr  = 1'b1;
                            fl        = '0;
                            if (i_head.cmd.size != '0) begin
                                n_size = i_head.cmd.size;
                                called = 1'b1;
                                fu     = send_request(fl, 1'b0, i_head.cmd.accept);
                            end
                        end
                        brr_pkg::OP_BYTE: begin
                            if (r_flags.busy) begin
                                if (r_fill < FW'(BLOCK_BYTES)) begin
                                    mem_we = 1'b1;
                                    n_fill = r_fill + FW'(1);
                                end
                                if (i_head.cmd.last) begin
                                    n_vm      = r_vm | (SLOT_ONE << r_wslot);
                                    n_wblocks = r_wblocks + 32'd1;
                                    n_wbytes  = r_wbytes[32] ? r_wbytes : r_wbytes + WB_STEP;
                                    n_wslot   = (r_wslot == SW'(BLOCK_SLOTS - 1)) ? '0
                                                : r_wslot + SW'(1);
                                    n_fill    = '0;
                                    fl.opened = 1'b1;
                                    fl.busy   = 1'b0;
                                    n_tleft   = '0;
                                end
                            end
                            if (i_head.cmd.last) begin
                                called = 1'b1;
                                fu     = follow_up(fl, &n_vm, n_wbytes >= {1'b0, r_size},
                                                   i_head.cmd.accept);
                            end
                        end
                        brr_pkg::OP_READ: begin
                            got = (r_vm != '0) && (r_pos < r_size);
                            if (got) begin
                                mem_re = 1'b1;
                                n_pos  = r_pos + 32'd1;
                                if (r_roff == OW'(BLOCK_BYTES - 1)) begin
                                    n_roff  = '0;
                                    n_vm    = r_vm & ~(SLOT_ONE << r_rslot);
                                    n_rslot = (r_rslot == SW'(BLOCK_SLOTS - 1)) ? '0
                                              : r_rslot + SW'(1);
                                    called  = 1'b1;
                                    fu      = follow_up(fl, &n_vm, done_now,
                                                        i_head.cmd.accept);
                                end else begin
                                    n_roff = r_roff + OW'(1);
                                end
                            end
                        end
                        brr_pkg::OP_TICK: begin
                            if (r_flags.busy) begin
                                n_tleft = tick_left;
                                if (tick_left == '0) begin
                                    fl.busy = 1'b0;
                                    called  = 1'b1;
                                    fu      = follow_up(fl, &r_vm, done_now,
                                                        i_head.cmd.accept);
                                end
                            end
                        end
                        brr_pkg::OP_RETRY: begin
                            if (r_flags.cached) begin
                                called = 1'b1;
                                fu     = follow_up(fl, &r_vm, done_now, i_head.cmd.accept);
                            end
                        end
                        default: begin
                        end
                    endcase

                    if (!called) begin
                        fu.flags = fl;
                    end
                    n_flags = fu.flags;
                    if (fu.arm) begin
                        n_tleft = r_ticks;
                    end

                    n_res.req_sent   = fu.sent;
                    n_res.req_index  = !fu.sent ? '0
                                       : (fu.is_end ? brr_pkg::END_INDEX : n_wblocks);
                    n_res.byte_valid = got;
                    n_res.byte_value = '0;
                    n_res.position   = n_pos;
                    n_res.opened     = n_flags.opened;
                    n_res.busy_res   = n_flags.busy;
                    n_res.cached     = n_flags.cached;

                    // A delivered byte waits in BK_READ for the registered slot memory read.
                    if (got) begin
                        n_state     = brr_pkg::BK_READ;
                        n_out_valid = 1'b0;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            brr_pkg::BK_READ: begin
                // A byte not written in the current file reads as zero.
                n_res.byte_value = r_rd_mark ? r_rd_data : '0;
                n_out_valid      = 1'b1;
                n_state          = brr_pkg::BK_EXEC;
            end
            default: begin
                n_state = brr_pkg::BK_EXEC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brr_pkg::BK_EXEC;
            r_ticks     <= brr_pkg::TIMEOUT_RESET;
            r_size      <= '0;
            r_wblocks   <= '0;
            r_wbytes    <= '0;
            r_wslot     <= '0;
            r_fill      <= '0;
            r_rslot     <= '0;
            r_roff      <= '0;
            r_pos       <= '0;
            r_vm        <= '0;
            r_flags     <= '0;
            r_tleft     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ticks     <= n_ticks;
            r_size      <= n_size;
            r_wblocks   <= n_wblocks;
            r_wbytes    <= n_wbytes;
            r_wslot     <= n_wslot;
            r_fill      <= n_fill;
            r_rslot     <= n_rslot;
            r_roff      <= n_roff;
            r_pos       <= n_pos;
            r_vm        <= n_vm;
            r_flags     <= n_flags;
            r_tleft     <= n_tleft;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark <= '0;
        end else if (mark_clr) begin
            r_mark <= '0;
        end else if (mem_we) begin
            r_mark[wr_addr] <= 1'b1;
        end
    end

    // Slot memory: one write port for arriving block bytes, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= i_head.cmd.data;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_mark <= r_mark[rd_addr];
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_res;

endmodule

@@ rtl/block_prefetch_ring_receiver.sv @@
`timescale 1ns / 1ps
// Top level of the block prefetch ring receiver.
// Depends on brr_pkg, brr_if, brr_front, brr_cmd_queue and brr_back.
//
// The receiver takes one event beat per item on i_in (valid/ready): start a file,
// a byte of an arriving block, a consumer read, a timeout tick, or a retry of a
// refused send. Every event produces exactly one result beat on o_out, carrying
// the block request (or end marker) handed to the link, the byte read, the read
// position and the opened, busy and cached flags.
// The front end decodes each beat into a command and pushes it into a two-entry
// queue; the back end pops commands and updates the ring state. The slot memory
// has a registered read port. Events sustain one per cycle while o_out is ready,
// except delivered reads, which also hold the back end in its read state.
// The timeout register is written through i_cfg_wr_en / i_cfg_wr_data; the user
// must write it while the block is idle, and the block does not enforce this.
// Reset (synchronous, active low) clears all counters, flags and the ring, sets
// the timeout to 500 ticks and empties the queue. The slot memory itself is
// never cleared; a written mark per byte, dropped at reset and at each new file,
// makes a byte not yet written in the current file read as zero.
// When the receiver of o_out stalls, the result register holds its beat, the
// queue fills, and i_in.ready drops until the results move again.
module block_prefetch_ring_receiver #(
    parameter int BLOCK_BYTES = 64,
    parameter int BLOCK_SLOTS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    brr_in_if.sink      i_in,
    brr_out_if.source   o_out,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    brr_pkg::t_cmd_beat push;
    brr_pkg::t_cmd_beat head;
    logic               q_ready;
    logic               pop;

    // Decode incoming event beats.
    brr_front u_front (
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push)
    );

    // Command queue lets the front end keep taking beats while the back end
    // waits on memory or on a stalled result.
    brr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (q_ready),
        .o_head  (head),
        .i_pop   (pop)
    );

    // Ring state, slot memory, link requests and the result register.
    brr_back #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .BLOCK_SLOTS (BLOCK_SLOTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out         (o_out)
    );

endmodule

@@ tb/block_prefetch_ring_receiver_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for block_prefetch_ring_receiver: event table, then random phases.
// Depends on brr_pkg, brr_if and the RTL of the receiver; nothing is read from disk.
module block_prefetch_ring_receiver_test;
    import brr_pkg::*;

    localparam int BLOCK_BYTES = 64;
    localparam int BLOCK_SLOTS = 4;
    localparam int RING_BYTES = BLOCK_BYTES * BLOCK_SLOTS;
    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 11;
    // Quiet cycles after the last awaited result, so any stray beat still shows up.
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_EVENTS = 245;

    // Action codes that the receiver does not decode; they only report status.
    localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

    typedef enum logic [1:0] {
        SINK_FLOW,
        SINK_JITTER,
        SINK_CHOKE
    } t_sink_mode;

    // One line of the directed script: the event, and a hand-written result where
    // the outcome is obvious; other lines take the result from the ring predictor.
    typedef struct {
        t_in_item  ev;
        bit        typed;
        t_out_item res;
    } t_script_line;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;

    brr_in_if  in_ch ();
    brr_out_if out_ch ();

    block_prefetch_ring_receiver #(
        .BLOCK_BYTES(BLOCK_BYTES),
        .BLOCK_SLOTS(BLOCK_SLOTS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .o_out        (out_ch),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Ring predictor. This is a private copy of the receiver state that is
    // advanced once per accepted event, in the order the events were accepted.
    // ------------------------------------------------------------------
    logic [15:0]            timeout_reg;
    logic [31:0]            file_size;
    logic [31:0]            blocks_written;
    logic [31:0]            blocks_read;
    logic [BLOCK_SLOTS-1:0] slot_valid;
    logic [7:0]             rd_off;
    logic [6:0]             fill;
    t_flags                 ring_flags;
    logic [15:0]            ticks_left;
    // Cleared at each new file, so a byte not written in this file reads as zero.
    logic [7:0]             ring_mem [RING_BYTES];

    // What the link did during the event being predicted.
    bit          link_ok;
    bit          link_sent;
    logic [31:0] link_index;

    t_out_item awaited_beats [$];
    int        mismatches = 0;
    int        cycle_count = 0;

    // Sender pacing and the shape of the blocks the random part streams in.
    int burst_left = 0;
    int bytes_into_block = 0;
    int block_goal = BLOCK_BYTES;

    // Receiver stall pattern.
    t_sink_mode sink_mode = SINK_FLOW;
    int         sink_mode_left = 0;

    function automatic void clear_ring();
        file_size = '0;
        blocks_written = '0;
        blocks_read = '0;
        slot_valid = '0;
        rd_off = '0;
        fill = '0;
        ring_flags = '0;
        ticks_left = '0;
        for (int i = 0; i < RING_BYTES; i++) begin
            ring_mem[i] = '0;
        end
    endfunction

    function automatic logic [31:0] read_position();
        return blocks_read * BLOCK_BYTES + rd_off % BLOCK_BYTES;
    endfunction

    // The comparison is done in 64 bits so a huge block count never wraps.
    function automatic bit fetch_done();
        return 64'(blocks_written) * 64'(BLOCK_BYTES) >= 64'(file_size);
    endfunction

    function automatic bit can_read();
        return slot_valid != '0 && read_position() < file_size;
    endfunction

    function automatic bit link_try(input logic [31:0] index);
        if (!link_ok) begin
            return 1'b0;
        end
        link_sent = 1'b1;
        link_index = index;
        return 1'b1;
    endfunction

    // The end marker waits while a block is still on its way; a refused marker
    // leaves both the closing and cached flags up for a later retry.
    function automatic void close_link();
        if (ring_flags.busy) begin
            ring_flags.closing = 1'b1;
        end else if (link_try(END_INDEX)) begin
            ring_flags.cached = 1'b0;
            ring_flags.closing = 1'b0;
            ring_flags.opened = 1'b0;
        end else begin
            ring_flags.cached = 1'b1;
            ring_flags.closing = 1'b1;
        end
    endfunction

    function automatic void request_next();
        if (ring_flags.busy) begin
            return;
        end
        if (fetch_done()) begin
            if (ring_flags.opened) begin
                close_link();
            end
        end else if (link_try(blocks_written)) begin
            ring_flags.busy = 1'b1;
            ring_flags.cached = 1'b0;
            ticks_left = timeout_reg;
        end else begin
            ring_flags.cached = 1'b1;
        end
    endfunction

    function automatic void resume_link();
        if (ring_flags.closing) begin
            close_link();
        end else if (slot_valid != {BLOCK_SLOTS{1'b1}}) begin
            request_next();
        end
    endfunction

    // Advances the ring by one event and returns its result beat.
    function automatic void ring_advance(input t_in_item ev, output t_out_item res);
        int slot;
        int addr;
        res = '0;
        link_ok = ev.link_accept;
        link_sent = 1'b0;
        link_index = '0;
        case (ev.action)
            ACT_NEW_FILE: begin
                clear_ring();
                if (ev.file_size_in != 0) begin
                    file_size = ev.file_size_in;
                    request_next();
                end
            end
            ACT_BLOCK_BYTE: begin
                if (ring_flags.busy) begin
                    slot = blocks_written % BLOCK_SLOTS;
                    // Bytes past the end of a block are dropped.
                    if (fill < BLOCK_BYTES) begin
                        addr = slot * BLOCK_BYTES + fill;
                        ring_mem[addr] = ev.block_byte;
                        fill++;
                    end
                    if (ev.block_last) begin
                        slot_valid[slot] = 1'b1;
                        blocks_written++;
                        fill = '0;
                        ring_flags.opened = 1'b1;
                        ring_flags.busy = 1'b0;
                        ticks_left = '0;
                    end
                end
                // Even a last byte that arrives unasked runs the follow-up.
                if (ev.block_last) begin
                    resume_link();
                end
            end
            ACT_READ_BYTE: begin
                if (can_read()) begin
                    res.byte_valid = 1'b1;
                    res.byte_value = ring_mem[rd_off];
                    rd_off = 8'((rd_off + 1) % RING_BYTES);
                    if (rd_off % BLOCK_BYTES == 0) begin
                        slot_valid[blocks_read % BLOCK_SLOTS] = 1'b0;
                        blocks_read++;
                        resume_link();
                    end
                end
            end
            ACT_TICK: begin
                if (ring_flags.busy) begin
                    // A timeout of zero fires on the first tick.
                    if (ticks_left > 0) begin
                        ticks_left--;
                    end
                    if (ticks_left == 0) begin
                        ring_flags.busy = 1'b0;
                        resume_link();
                    end
                end
            end
            ACT_RETRY: begin
                if (ring_flags.cached) begin
                    resume_link();
                end
            end
            default: begin
            end
        endcase
        res.req_sent = link_sent;
        res.req_index = link_index;
        res.position = read_position();
        res.opened = ring_flags.opened;
        res.busy_res = ring_flags.busy;
        res.cached = ring_flags.cached;
    endfunction

    // ------------------------------------------------------------------
    // Random event source. Most events follow the protocol: blocks are streamed
    // while a request is outstanding, the consumer reads what is valid, refused
    // sends are retried and finished files are followed by new ones. A share of
    // blocks is short or overlong, and some events are plain noise.
    // ------------------------------------------------------------------
    function automatic t_in_item pick_event();
        t_in_item   ev;
        int unsigned roll;
        int unsigned shape;
        logic [2:0] noise;
        roll = $urandom_range(0, 99);
        noise = ($urandom_range(0, 3) == 0) ? ACT_RETRY : 3'(ACT_UNUSED_LO + $urandom_range(0, 2));
        ev.action = ACT_TICK;
        ev.file_size_in = $urandom();
        ev.block_byte = 8'($urandom());
        ev.block_last = 1'($urandom_range(0, 1));
        ev.link_accept = ($urandom_range(0, 99) < 85);
        if (roll < 2) begin
            ev.action = ACT_NEW_FILE;
        end else if (ring_flags.busy) begin
            if (roll < 70) begin
                ev.action = ACT_BLOCK_BYTE;
            end else if (roll < 88) begin
                ev.action = ACT_READ_BYTE;
            end else if (roll < 95) begin
                ev.action = ACT_TICK;
            end else begin
                ev.action = noise;
            end
        end else begin
            if (ring_flags.cached && roll < 45) begin
                ev.action = ACT_RETRY;
            end else if (can_read() && roll < 80) begin
                ev.action = ACT_READ_BYTE;
            end else if (fetch_done() && roll < 90) begin
                ev.action = ACT_NEW_FILE;
            end else if (roll < 93) begin
                ev.action = ACT_TICK;
            end else if (roll < 96) begin
                ev.action = ACT_BLOCK_BYTE;
            end else begin
                ev.action = noise;
            end
        end

        if (ev.action == ACT_NEW_FILE) begin
            // Mostly small files, some whole-block sizes, a few cancels and a
            // few arbitrary 32-bit sizes that never finish.
            shape = $urandom_range(0, 99);
            if (shape < 5) begin
                ev.file_size_in = '0;
            end else if (shape < 30) begin
                ev.file_size_in = BLOCK_BYTES * $urandom_range(1, 9);
            end else if (shape >= 40) begin
                ev.file_size_in = $urandom_range(1, 700);
            end
            bytes_into_block = 0;
        end else if (ev.action == ACT_BLOCK_BYTE) begin
            bytes_into_block++;
            ev.block_last = (bytes_into_block >= block_goal);
            if (ev.block_last) begin
                bytes_into_block = 0;
                shape = $urandom_range(0, 99);
                if (shape < 6) begin
                    block_goal = $urandom_range(1, BLOCK_BYTES - 1);
                end else if (shape < 14) begin
                    block_goal = $urandom_range(BLOCK_BYTES + 1, BLOCK_BYTES + 8);
                end else begin
                    block_goal = BLOCK_BYTES;
                end
            end
        end
        return ev;
    endfunction

    // ------------------------------------------------------------------
    // Sender. Holds valid until the beat is taken, predicts its result at
    // the accepting edge, then either keeps valid high for the next beat of
    // the burst or drops it for a random gap.
    // ------------------------------------------------------------------
    task automatic push_event(input t_in_item ev, input bit typed, input t_out_item typed_res);
        t_out_item predicted;
        in_ch.valid <= 1'b1;
        in_ch.data <= ev;
        do @(posedge i_clk); while (!in_ch.ready);
        ring_advance(ev, predicted);
        awaited_beats.push_back(typed ? typed_res : predicted);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 30);
            if ($urandom_range(0, 99) >= 30) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    endtask

    // Lets every awaited beat arrive, then gives the block a few quiet cycles.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (awaited_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result checking against the oldest awaited beat.
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    function automatic void check_beat(input t_out_item got);
        t_out_item want;
        if (awaited_beats.size() == 0) begin
            mismatches++;
            $error("result beat with nothing awaited: 0x%0h", got);
            return;
        end
        want = awaited_beats.pop_front();
        check_field("req_sent", want.req_sent, got.req_sent);
        check_field("req_index", want.req_index, got.req_index);
        check_field("byte_valid", want.byte_valid, got.byte_valid);
        check_field("byte_value", want.byte_value, got.byte_value);
        check_field("position", want.position, got.position);
        check_field("opened", want.opened, got.opened);
        check_field("busy_res", want.busy_res, got.busy_res);
        check_field("cached", want.cached, got.cached);
    endfunction

    // Receiver: checks each beat taken at this edge, then picks ready for the
    // next cycle. It switches between free flow, random stalls and a choked
    // mode that takes one beat in five, each for a random stretch of cycles.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            check_beat(out_ch.data);
        end
        if (sink_mode_left == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 2));
            sink_mode_left = $urandom_range(20, 200);
        end else begin
            sink_mode_left--;
        end
        case (sink_mode)
            SINK_FLOW: begin
                out_ch.ready <= 1'b1;
            end
            SINK_JITTER: begin
                out_ch.ready <= ($urandom_range(0, 99) < 65);
            end
            default: begin
                out_ch.ready <= (cycle_count % 5 == 0);
            end
        endcase
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    t_script_line script [25];
    logic [15:0]  phase_timeout [6];

    initial begin
        t_in_item ev;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        clear_ring();
        timeout_reg = TIMEOUT_RESET;

        // Directed script, run with a timeout of two ticks so the timeout path
        // shows up within a handful of events. Fields of each event are
        // action, file size, block byte, last flag, link accept; result fields
        // are req_sent, req_index, byte_valid, byte_value, position, opened,
        // busy_res, cached.
        script = '{
            // An undecoded action with every field at its top value.
            '{'{ACT_UNUSED_HI, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1}, 1'b1, '0},
            // A read with no valid slot delivers nothing.
            '{'{ACT_READ_BYTE, 32'h0, 8'h00, 1'b0, 1'b1}, 1'b1, '0},
            // A last byte with no request out is dropped; the follow-up finds nothing to do.
            '{'{ACT_BLOCK_BYTE, 32'h0, 8'hFF, 1'b1, 1'b1}, 1'b1, '0},
            '{'{ACT_TICK, 32'h0, 8'h00, 1'b0, 1'b1}, 1'b1, '0},
            // A zero size cancels.
            '{'{ACT_NEW_FILE, 32'h0, 8'h00, 1'b0, 1'b1}, 1'b1, '0},
            // The link refuses the first request, so it is cached.
            '{'{ACT_NEW_FILE, 32'd130, 8'h00, 1'b0, 1'b0}, 1'b1,
              '{1'b0, 32'h0, 1'b0, 8'h00, 32'h0, 1'b0, 1'b0, 1'b1}},
            // The retry goes out as block 0.
            '{'{ACT_RETRY, 32'h0, 8'h00, 1'b0, 1'b1}, 1'b1,
              '{1'b1, 32'h0, 1'b0, 8'h00, 32'h0, 1'b0, 1'b1, 1'b0}},
            // Two ticks run the request out; the reissue is refused.
            '{'{ACT_TICK, 32'h0, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
            '{'{ACT_TICK, 32'h0, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
            '{'{ACT_BLOCK_BYTE, 32'h0, 8'hA5, 1'b0, 1'b1}, 1'b0, '0},
            '{'{ACT_RETRY, 32'h0, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
            // Largest file size while a request is out.
            '{'{ACT_NEW_FILE, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
            // A five-byte file: one short block, then the end marker.
            '{'{ACT_NEW_FILE, 32'd5, 8'h00, 1'b0, 1'b1}, 1'b1,
              '{1'b1, 32'h0, 1'b0, 8'h00, 32'h0, 1'b0, 1'b1, 1'b0}},
            '{'{ACT_BLOCK_BYTE, 32'h0, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
            '{'{ACT_BLOCK_BYTE, 32'h0, 8'hFF, 1'b0, 1'b1}, 1'b0, '0},
            '{'{ACT_BLOCK_BYTE, 32'h0, 8'h5A, 1'b0, 1'b1}, 1'b0, '0},
            '{'{ACT_BLOCK_BYTE, 32'h0, 8'h81, 1'b0, 1'b1}, 1'b0, '0},
            // The end marker is refused and stays cached with closing set.
            '{'{ACT_BLOCK_BYTE, 32'h0, 8'h7E, 1'b1, 1'b0}, 1'b0, '0},
            '{'{ACT_RETRY, 32'h0, 8'h00, 1'b0, 1'b1}, 1'b1,
              '{1'b1, END_INDEX, 1'b0, 8'h00, 32'h0, 1'b0, 1'b0, 1'b0}},
            // The consumer drains the five bytes, then hits the file size.
            '{'{ACT_READ_BYTE, 32'h0, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
            '{'{ACT_READ_BYTE, 32'h0, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
            '{'{ACT_READ_BYTE, 32'h0, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
            '{'{ACT_READ_BYTE, 32'h0, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
            '{'{ACT_READ_BYTE, 32'h0, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
            '{'{ACT_READ_BYTE, 32'h0, 8'h00, 1'b0, 1'b1}, 1'b0, '0}
        };

        // Timeout for each phase: the directed value, one, the largest value, zero, a
        // random small value and the reset value.
        phase_timeout = '{16'd2, 16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(2, 40)),
                          TIMEOUT_RESET};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (phase_timeout[p]) begin
            // The register only changes while nothing is in flight.
            settle();
            i_cfg_wr_en <= 1'b1;
            i_cfg_wr_data <= phase_timeout[p];
            @(posedge i_clk);
            i_cfg_wr_en <= 1'b0;
            timeout_reg = phase_timeout[p];
            if (p == 0) begin
                foreach (script[n]) begin
                    push_event(script[n].ev, script[n].typed, script[n].res);
                end
            end else begin
                repeat (PHASE_EVENTS) begin
                    ev = pick_event();
                    push_event(ev, 1'b0, '0);
                end
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/brr_pkg.sv
rtl/brr_if.sv
rtl/brr_front.sv
rtl/brr_cmd_queue.sv
rtl/brr_back.sv
rtl/block_prefetch_ring_receiver.sv
tb/block_prefetch_ring_receiver_test.sv
